@@ rtl/core/dnle_pkg.sv @@
`default_nettype none

package dnle_pkg;

  // label length and space limits
  localparam int MAX_LABEL_DEF = 63;
  localparam int LEN_W         = 6;
  localparam int LIMIT_W       = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd255;

  // byte codes
  localparam logic [7:0] SEPARATOR  = 8'h2E;
  localparam logic [7:0] TERMINATOR = 8'h00;
  localparam int         HIGH_BIT   = 7;

  // label store words hold two name bytes each
  localparam int WORD_W = 16;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_SPACE_LIMIT = 1'b0;

  typedef struct packed {
    logic             has_label;
    logic             buf_sel;
    logic [LEN_W-1:0] len;
    logic             non_ascii;
    logic             term;
  } dnle_cmd_t;

  typedef struct packed {
    logic valid;
    logic buf_sel;
  } dnle_rel_t;

  typedef struct packed {
    logic               valid;
    logic [LIMIT_W-1:0] value;
  } dnle_cfg_t;

  // word address bits of one label buffer
  function automatic int word_bits(input int max_label);
    int words;
    words = max_label / 2 + 1;
    return (words > 1) ? $clog2(words) : 1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dnle_ram.sv @@
`default_nettype none

module dnle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dnle_queue.sv @@
`default_nettype none

module dnle_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire dnle_pkg::dnle_cmd_t  push_cmd,
  output logic                      full,
  input  wire logic                 pop,
  output dnle_pkg::dnle_cmd_t       head,
  output logic                      empty
);

  dnle_pkg::dnle_cmd_t entry_r [dnle_pkg::QUEUE_DEPTH];
  logic [dnle_pkg::QPTR_W-1:0] wptr_r;
  logic [dnle_pkg::QPTR_W-1:0] rptr_r;
  logic [dnle_pkg::QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == dnle_pkg::QCNT_W'(dnle_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + dnle_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + dnle_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + dnle_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - dnle_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dnle_front.sv @@
`default_nettype none

module dnle_front #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_name_byte,
  input  wire logic                              in_byte_valid,
  input  wire logic                              in_is_last,
  input  wire dnle_pkg::dnle_cfg_t               cfg,
  input  wire logic [dnle_pkg::LIMIT_W-1:0]      space_limit,
  output logic                                   q_push,
  output dnle_pkg::dnle_cmd_t                    q_cmd,
  input  wire logic                              q_full,
  input  wire dnle_pkg::dnle_rel_t               rel,
  output logic                                   ram_wr_en,
  output logic [dnle_pkg::word_bits(MAX_LABEL):0] ram_wr_addr,
  output logic [dnle_pkg::WORD_W-1:0]            ram_wr_data
);

  localparam int CNT_W = $clog2(MAX_LABEL + 1);
  localparam int WB    = dnle_pkg::word_bits(MAX_LABEL);
  localparam int LW    = dnle_pkg::LIMIT_W;

  logic [CNT_W-1:0] count_r;
  logic             hb_r;
  logic [LW-1:0]    space_left_r;
  logic             exh_r;
  logic             wbuf_r;
  logic [1:0]       busy_r;
  logic [7:0]       hold_r;

  logic             acc;
  logic             is_sep;
  logic             take;
  logic             data_byte;
  logic             store_byte;
  logic             close;
  logic [CNT_W-1:0] cnt_close;
  logic             hb_close;
  logic [LW-1:0]    cnt_ext;
  logic [LW-1:0]    len_cut;
  logic [LW-1:0]    space_after;
  logic             label_emit;
  logic [CNT_W:0]   widx;
  logic             first_slot;

  assign in_ready = !q_full && !busy_r[wbuf_r];
  assign acc      = in_valid && in_ready;

  assign is_sep     = (in_name_byte == dnle_pkg::SEPARATOR);
  assign take       = in_byte_valid && !exh_r;
  assign data_byte  = take && !is_sep;
  assign store_byte = data_byte && (count_r < CNT_W'(MAX_LABEL));
  assign close      = (take && is_sep) || in_is_last;

  assign cnt_close = store_byte ? (count_r + CNT_W'(1)) : count_r;
  assign hb_close  = hb_r || (data_byte && in_name_byte[dnle_pkg::HIGH_BIT]);

  // cut the label to the space left, one byte goes to the length prefix
  assign cnt_ext     = LW'(cnt_close);
  assign len_cut     = (space_left_r <= cnt_ext) ? (space_left_r - LW'(1)) : cnt_ext;
  assign space_after = space_left_r - len_cut - LW'(1);
  assign label_emit  = close && !exh_r && (space_left_r != '0) && (len_cut != '0);

  assign q_push            = acc && (label_emit || in_is_last);
  assign q_cmd.has_label   = label_emit;
  assign q_cmd.buf_sel     = wbuf_r;
  assign q_cmd.len         = dnle_pkg::LEN_W'(len_cut);
  assign q_cmd.non_ascii   = hb_close;
  assign q_cmd.term        = in_is_last;

  // byte i lands in word (i+1)/2: word 0 holds byte 0, later words hold pairs
  assign widx        = ({1'b0, count_r} + (CNT_W + 1)'(1)) >> 1;
  assign first_slot  = count_r[0] || (count_r == '0);
  assign ram_wr_en   = acc && store_byte;
  assign ram_wr_addr = {wbuf_r, widx[WB-1:0]};
  assign ram_wr_data = first_slot ? {in_name_byte, 8'h00} : {hold_r, in_name_byte};

  always_ff @(posedge clk) begin
    if (acc && store_byte && count_r[0]) begin
      hold_r <= in_name_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      hb_r         <= 1'b0;
      space_left_r <= dnle_pkg::LIMIT_RESET;
      exh_r        <= 1'b0;
      wbuf_r       <= 1'b0;
      busy_r       <= '0;
    end else begin
      if (rel.valid) begin
        busy_r[rel.buf_sel] <= 1'b0;
      end
      if (acc) begin
        if (close) begin
          count_r <= '0;
          hb_r    <= 1'b0;
        end else begin
          count_r <= cnt_close;
          hb_r    <= hb_close;
        end
      end
      if (acc && label_emit) begin
        busy_r[wbuf_r] <= 1'b1;
        wbuf_r         <= !wbuf_r;
      end
      // register write wins, then end of name, then the label just sent
      if (cfg.valid) begin
        space_left_r <= cfg.value;
        exh_r        <= (cfg.value == '0);
      end else if (acc && in_is_last) begin
        space_left_r <= space_limit;
        exh_r        <= (space_limit == '0);
      end else if (acc && label_emit) begin
        space_left_r <= space_after;
        exh_r        <= (space_after == '0);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dnle_back.sv @@
`default_nettype none

module dnle_back #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_empty,
  input  wire dnle_pkg::dnle_cmd_t                q_head,
  output logic                                    q_pop,
  output logic                                    ram_rd_en,
  output logic [dnle_pkg::word_bits(MAX_LABEL):0] ram_rd_addr,
  input  wire logic [dnle_pkg::WORD_W-1:0]        ram_rd_data,
  output dnle_pkg::dnle_rel_t                     rel,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_first_byte,
  output logic [7:0]                              out_second_byte,
  output logic                                    out_second_valid,
  output logic                                    out_non_ascii_label,
  output logic                                    out_end_of_run
);

  localparam int WB = dnle_pkg::word_bits(MAX_LABEL);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_TERM = 2'd3;

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;
  dnle_pkg::dnle_cmd_t cmd_r;
  logic [WB-1:0]       ridx_r;
  logic [WB-1:0]       ridx_nxt;

  logic       out_valid_r;
  logic [7:0] first_r;
  logic [7:0] second_r;
  logic       sv_r;
  logic       na_r;
  logic       eor_r;

  logic       out_free;
  logic       load;
  logic [7:0] first_nxt;
  logic [7:0] second_nxt;
  logic       sv_nxt;
  logic       na_nxt;
  logic       eor_nxt;
  logic [7:0] r2;
  logic [7:0] len8;
  logic       pair_ok;
  logic       last_res;

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign ram_rd_en = (state_r == S_RD);
  assign ram_rd_addr = {cmd_r.buf_sel, ridx_r};

  // result r carries bytes 2r and 2r+1 of length prefix plus data
  assign r2       = 8'({ridx_r, 1'b0});
  assign len8     = 8'(cmd_r.len);
  assign pair_ok  = (r2 < len8);
  assign last_res = ((r2 + 8'd1) >= len8);

  assign rel.valid   = (state_r == S_WR) && out_free && last_res;
  assign rel.buf_sel = cmd_r.buf_sel;

  always_comb begin
    state_nxt  = state_r;
    ridx_nxt   = ridx_r;
    load       = 1'b0;
    first_nxt  = dnle_pkg::TERMINATOR;
    second_nxt = 8'h00;
    sv_nxt     = 1'b0;
    na_nxt     = 1'b0;
    eor_nxt    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_head.has_label ? S_RD : S_TERM;
          ridx_nxt  = '0;
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          load    = 1'b1;
          na_nxt  = cmd_r.non_ascii;
          eor_nxt = last_res && !cmd_r.term;
          if (ridx_r == '0) begin
            first_nxt  = len8;
            second_nxt = ram_rd_data[15:8];
            sv_nxt     = 1'b1;
          end else begin
            first_nxt  = ram_rd_data[15:8];
            second_nxt = pair_ok ? ram_rd_data[7:0] : 8'h00;
            sv_nxt     = pair_ok;
          end
          if (last_res) begin
            state_nxt = cmd_r.term ? S_TERM : S_IDLE;
          end else begin
            ridx_nxt  = ridx_r + WB'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    ridx_r <= ridx_nxt;
    if (load) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      sv_r     <= sv_nxt;
      na_r     <= na_nxt;
      eor_r    <= eor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_first_byte      = first_r;
  assign out_second_byte     = second_r;
  assign out_second_valid    = sv_r;
  assign out_non_ascii_label = na_r;
  assign out_end_of_run      = eor_r;

endmodule

`default_nettype wire

@@ rtl/core/dns_name_label_encoder.sv @@
// path: a closing beat reaches out_valid through the queue, the back end pick-up, one
//   label store read and the output register; a terminator alone skips the store read
// throughput: one input beat per cycle while a label buffer and a queue slot are free;
//   the back end loads each result beat after a label store read, loads a terminator
//   directly, and picks up each queued command in its idle state
// reset: synchronous active-low rst_n clears control state, space_limit returns to 255
`default_nettype none

module dns_name_label_encoder #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel, one name byte per beat
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_name_byte,
  input  wire logic                            in_byte_valid,
  input  wire logic                            in_is_last,
  // result channel, up to two encoded bytes per beat
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_first_byte,
  output logic [7:0]                           out_second_byte,
  output logic                                 out_second_valid,
  output logic                                 out_non_ascii_label,
  output logic                                 out_end_of_run,
  // register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dnle_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [dnle_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [dnle_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  localparam int WB = dnle_pkg::word_bits(MAX_LABEL);
  // two label buffers, double buffered so the front fills one while the back drains
  localparam int RAM_DEPTH = 2 * (1 << WB);

  // register decode, byte offset ignored
  logic                           reg_hit;
  logic                           reg_wr;
  logic [dnle_pkg::LIMIT_W-1:0]   space_limit_r;
  dnle_pkg::dnle_cfg_t            cfg;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[dnle_pkg::APB_ADDR_W-1:2] == dnle_pkg::REG_SPACE_LIMIT);
  assign reg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? dnle_pkg::APB_DATA_W'(space_limit_r) : '0;

  assign cfg.valid = reg_wr;
  assign cfg.value = pwdata[dnle_pkg::LIMIT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_limit_r <= dnle_pkg::LIMIT_RESET;
    end else if (reg_wr) begin
      space_limit_r <= cfg.value;
    end
  end

  // front to back command queue
  logic                    q_push;
  logic                    q_full;
  logic                    q_pop;
  logic                    q_empty;
  dnle_pkg::dnle_cmd_t     q_cmd;
  dnle_pkg::dnle_cmd_t     q_head;
  dnle_pkg::dnle_rel_t     rel;

  // label store ports
  logic                          ram_wr_en;
  logic [WB:0]                   ram_wr_addr;
  logic [dnle_pkg::WORD_W-1:0]   ram_wr_data;
  logic                          ram_rd_en;
  logic [WB:0]                   ram_rd_addr;
  logic [dnle_pkg::WORD_W-1:0]   ram_rd_data;

  // front: classifies bytes, fills the open label, does the space accounting
  dnle_front #(
    .MAX_LABEL (MAX_LABEL)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_name_byte  (in_name_byte),
    .in_byte_valid (in_byte_valid),
    .in_is_last    (in_is_last),
    .cfg           (cfg),
    .space_limit   (space_limit_r),
    .q_push        (q_push),
    .q_cmd         (q_cmd),
    .q_full        (q_full),
    .rel           (rel),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data)
  );

  dnle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // label store, byte pairs per word
  dnle_ram #(
    .WIDTH (dnle_pkg::WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_label_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // back: reads finished labels, emits length prefix, data pairs and terminator
  dnle_back #(
    .MAX_LABEL (MAX_LABEL)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .ram_rd_en           (ram_rd_en),
    .ram_rd_addr         (ram_rd_addr),
    .ram_rd_data         (ram_rd_data),
    .rel                 (rel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_first_byte      (out_first_byte),
    .out_second_byte     (out_second_byte),
    .out_second_valid    (out_second_valid),
    .out_non_ascii_label (out_non_ascii_label),
    .out_end_of_run      (out_end_of_run)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command queue underflow");

  // a label is never handed over in the buffer the back end is just releasing
  a_buf_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (rel.valid && q_push && q_cmd.has_label) |-> (rel.buf_sel != q_cmd.buf_sel))
    else $error("label buffer handed over while still draining");

  // a result beat without a second byte carries zero there
  a_second_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_second_valid) |-> (out_second_byte == 8'h00))
    else $error("second byte not cleared");

  // a stalled result beat holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable({out_first_byte,
      out_second_byte, out_second_valid, out_non_ascii_label, out_end_of_run})))
    else $error("result beat changed while stalled");

endmodule

`default_nettype wire
